// File: src/vmag_pkg.sv
// shared types, constants and helpers for the vector magnitude block
// no dependencies
package vmag_pkg;

    localparam int COMP_W   = 16;
    localparam int SUM_W    = 32;   // x^2 + y^2 + z^2 stays below 2^32
    localparam int PP_W     = 61;   // (x*dx)^2 stays at or below 2^60
    localparam int ACC_W    = 62;   // weighted sum of squared errors
    localparam int HALF_W   = 31;   // split of the weighted sum for the scale product
    localparam int KMUL_W   = 35;   // 4 * scale^2 for scales up to 65536
    localparam int PROD_W   = HALF_W + KMUL_W;
    localparam int NUM_W    = 96;   // dividend of the error quotient
    localparam int DEN_W    = 48;   // sum of squares shifted by 16
    localparam int QUO_W    = 49;   // the quotient never reaches 2^49
    localparam int WSQ_W    = 50;   // quotient padded to an even width
    localparam int MAG_W    = 16;
    localparam int ERR_W    = 21;
    localparam int ROOTW_W  = WSQ_W / 2;
    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    typedef struct packed {
        logic [SUM_W-1:0] sum_sq;
        logic [PP_W-1:0]  pp_x;
        logic [PP_W-1:0]  pp_y;
        logic [PP_W-1:0]  pp_z;
    } front_item_t;

    function automatic logic [COMP_W-1:0] abs16(input logic [COMP_W-1:0] v);
        logic [COMP_W-1:0] neg;
        neg = (~v) + COMP_W'(1);
        return v[COMP_W-1] ? neg : v;
    endfunction

endpackage

// File: src/vector3_magnitude_with_error.sv
// top level of the 3d vector magnitude with error propagation block
// depends on vmag_pkg, vmag_front, vmag_queue, vmag_back
//
// s_ channel: one item per handshake, six signed q8.8 values (components and
// their absolute errors). m_ channel: one result item per input item, in order:
// magnitude (unsigned q8.8, truncated root), error_units (error rounded to
// counts of 1/ERROR_SCALE, saturated to 21 bits) and a zero_vector flag in tuser.
// an item passes through the bit-per-stage pipelines: a 16-stage root for the
// magnitude, a 49-stage divider and a 25-stage root for the error.
// throughput is one item per cycle while the output is not stalled. the front
// (abs and squares) feeds a 4-entry queue and the back pipeline drains it; when
// m_tready is low with a result waiting, the back pipeline holds, the queue
// fills, and only then s_tready drops.
// a zero vector gives magnitude 0, error 0 and the flag set.
// reset (aresetn low, synchronous) empties the queue and clears all valid
// bits; no item is in flight after reset.
module vector3_magnitude_with_error import vmag_pkg::*; #(
    parameter int ERROR_SCALE = 10000
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // comp_x, comp_y, comp_z, err_x, err_y, err_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // magnitude[15:0], error_units[36:16], zero pad
    output logic [0:0]   m_tuser    // zero_vector
);

    logic         push_valid, push_ready, pop_valid, pop;
    front_item_t  push_data, pop_data;

    vmag_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    vmag_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    vmag_back #(.ERROR_SCALE(ERROR_SCALE)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_zero_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[36:16] == '0))
        else $error("zero vector with nonzero error");

    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == '0))
        else $error("zero vector with nonzero magnitude");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: src/vmag_front.sv
// front part: takes input items, forms squares and error products
// depends on vmag_pkg
module vmag_front import vmag_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,
    output logic              push_valid,
    input  logic              push_ready,
    output front_item_t       push_data
);

    logic                    en;
    logic                    v1_reg, v2_reg;
    logic [COMP_W-1:0]       ax, ay, az, adx, ady, adz;
    logic [SUM_W-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]        px_reg, py_reg, pz_reg;
    front_item_t             item_reg;
    logic [2*SUM_W-1:0]      ppx, ppy, ppz;

    assign en       = !v2_reg || push_ready;
    assign s_tready = en;

    assign ax  = abs16(s_tdata[15:0]);
    assign ay  = abs16(s_tdata[31:16]);
    assign az  = abs16(s_tdata[47:32]);
    assign adx = abs16(s_tdata[63:48]);
    assign ady = abs16(s_tdata[79:64]);
    assign adz = abs16(s_tdata[95:80]);

    assign ppx = (2*SUM_W)'(px_reg) * (2*SUM_W)'(px_reg);
    assign ppy = (2*SUM_W)'(py_reg) * (2*SUM_W)'(py_reg);
    assign ppz = (2*SUM_W)'(pz_reg) * (2*SUM_W)'(pz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= SUM_W'(ax) * SUM_W'(ax);
            sqy_reg <= SUM_W'(ay) * SUM_W'(ay);
            sqz_reg <= SUM_W'(az) * SUM_W'(az);
            px_reg  <= SUM_W'(ax) * SUM_W'(adx);
            py_reg  <= SUM_W'(ay) * SUM_W'(ady);
            pz_reg  <= SUM_W'(az) * SUM_W'(adz);
            item_reg.sum_sq <= sqx_reg + sqy_reg + sqz_reg;
            item_reg.pp_x   <= ppx[PP_W-1:0];
            item_reg.pp_y   <= ppy[PP_W-1:0];
            item_reg.pp_z   <= ppz[PP_W-1:0];
        end
    end

    assign push_valid = v2_reg;
    assign push_data  = item_reg;

endmodule

// File: src/vmag_queue.sv
// short queue between front and back parts
// depends on vmag_pkg
module vmag_queue import vmag_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  front_item_t  push_data,
    output logic         pop_valid,
    input  logic         pop,
    output front_item_t  pop_data
);

    front_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: src/vmag_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
// no dependencies
module vmag_sqrt_pipe #(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_value,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int RW     = IN_W + 1;

    logic [RW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [RW-1:0]     rem_in, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        if (k == 0) begin : g_first
            assign rem_in  = RW'(in_value);
            assign root_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // trial = (2*root + 2^b) * 2^b
        assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));

        always_comb begin
            rem_next  = rem_in;
            root_next = root_in;
            if (trial <= rem_in) begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: src/vmag_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
// no dependencies; the caller guarantees the quotient fits in Q_W bits
module vmag_div_pipe #(
    parameter int N_W    = 96,
    parameter int D_W    = 48,
    parameter int Q_W    = 49,
    parameter int SIDE_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [N_W-1:0]      in_num,
    input  logic [D_W-1:0]      in_den,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [Q_W-1:0]      out_quo,
    output logic [SIDE_W-1:0]   out_side
);

    logic [D_W-1:0]    rem_reg  [Q_W];
    logic [N_W-1:0]    num_reg  [Q_W];
    logic [D_W-1:0]    den_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              vld_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int QB = Q_W - 1 - k;
        logic [D_W-1:0]    rem_in, den_in, rem_next;
        logic [N_W-1:0]    num_in;
        logic [Q_W-1:0]    quo_in, quo_next;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [D_W:0]      sh, diff;

        if (k == 0) begin : g_first
            assign rem_in  = D_W'(in_num >> Q_W);
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign sh   = {rem_in, num_in[QB]};
        assign diff = sh - {1'b0, den_in};

        always_comb begin
            rem_next = sh[D_W-1:0];
            quo_next = quo_in;
            if (sh >= {1'b0, den_in}) begin
                rem_next = diff[D_W-1:0];
                quo_next = quo_in | (Q_W'(1) << QB);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_in;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// File: src/vmag_back.sv
// back part: scale product, magnitude root, error quotient and root, output register
// depends on vmag_pkg, vmag_sqrt_pipe, vmag_div_pipe
module vmag_back import vmag_pkg::*; #(
    parameter int ERROR_SCALE = 10000
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop,
    input  front_item_t   pop_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic [0:0]    m_tuser
);

    localparam logic [KMUL_W-1:0] KMUL =
        KMUL_W'(64'd4 * 64'(ERROR_SCALE) * 64'(ERROR_SCALE));

    localparam int SQS_SIDE = NUM_W + SUM_W + 1;
    localparam int DIV_SIDE = MAG_W + 1;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, vo_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [SUM_W-1:0]     s1_reg, s2_reg, s3_reg;
    logic [PROD_W-1:0]    lo_reg, hi_reg;
    logic [NUM_W-1:0]     num_reg;
    logic                 zero3_reg;

    logic                 sq_valid;
    logic [MAG_W-1:0]     sq_root;
    logic [SQS_SIDE-1:0]  sq_side;
    logic                 dv_valid;
    logic [QUO_W-1:0]     dv_quo;
    logic [DIV_SIDE-1:0]  dv_side;
    logic                 wr_valid;
    logic [ROOTW_W-1:0]   wr_root;
    logic [DIV_SIDE-1:0]  wr_side;

    logic [ROOTW_W-1:0]   half_next;
    logic [ERR_W-1:0]     err_next;
    logic [MAG_W-1:0]     mag_reg;
    logic [ERR_W-1:0]     err_reg;
    logic                 zero_reg;

    assign en  = !vo_reg || m_tready;
    assign pop = en && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= pop_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= wr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg   <= ACC_W'(pop_data.pp_x) + ACC_W'(pop_data.pp_y)
                       + ACC_W'(pop_data.pp_z);
            s1_reg    <= pop_data.sum_sq;
            lo_reg    <= PROD_W'(acc_reg[HALF_W-1:0]) * PROD_W'(KMUL);
            hi_reg    <= PROD_W'(acc_reg[ACC_W-1:HALF_W]) * PROD_W'(KMUL);
            s2_reg    <= s1_reg;
            num_reg   <= (NUM_W'(hi_reg) << HALF_W) + NUM_W'(lo_reg);
            s3_reg    <= s2_reg;
            zero3_reg <= (s2_reg == '0);
        end
    end

    vmag_sqrt_pipe #(.IN_W(SUM_W), .SIDE_W(SQS_SIDE)) u_sqrt_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_value  (s3_reg),
        .in_side   ({num_reg, s3_reg, zero3_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    vmag_div_pipe #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUO_W), .SIDE_W(DIV_SIDE)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_side[SQS_SIDE-1 -: NUM_W]),
        .in_den    ({sq_side[SUM_W:1], 16'h0000}),
        .in_side   ({sq_root, sq_side[0]}),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    vmag_sqrt_pipe #(.IN_W(WSQ_W), .SIDE_W(DIV_SIDE)) u_sqrt_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_value  (WSQ_W'(dv_quo)),
        .in_side   (dv_side),
        .out_valid (wr_valid),
        .out_root  (wr_root),
        .out_side  (wr_side)
    );

    // largest odd value not above the root gives the rounded count
    assign half_next = ROOTW_W'((ROOTW_W+1)'(wr_root) + 1'b1 >> 1);

    always_comb begin
        if (wr_side[0]) begin
            err_next = '0;
        end else if (half_next > ROOTW_W'(ERR_MAX)) begin
            err_next = ERR_MAX;
        end else begin
            err_next = half_next[ERR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= wr_side[DIV_SIDE-1:1];
            err_reg  <= err_next;
            zero_reg <= wr_side[0];
        end
    end

    assign m_tvalid   = vo_reg;
    assign m_tdata    = {3'b000, err_reg, mag_reg};
    assign m_tuser[0] = zero_reg;

endmodule

// File: tb/tb.sv
// testbench for vector3_magnitude_with_error: directed and random vectors
// checked against an exact integer model of magnitude and propagated error
// depends on vmag_pkg and the top level of the block
`timescale 1ns / 100ps

module tb;
    import vmag_pkg::*;

    localparam int SCALE = 10000;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [ERR_W-1:0] error_units;
        logic             zero_vector;
    } vmag_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic [0:0]   m_tuser;

    vmag_result_t expected_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           hold_off = 0;
    bit           burst_mode = 1'b1;
    bit           stall_mode = 1'b1;

    vector3_magnitude_with_error #(.ERROR_SCALE(SCALE)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] mag16(input logic [15:0] v);
        return v[15] ? 64'(17'h10000 - v) : 64'(v);
    endfunction

    // exact integer model of magnitude and propagated error
    function automatic vmag_result_t predict_magnitude(input logic [95:0] d);
        logic [63:0]  x, y, z, dx, dy, dz, s, r, c;
        logic [127:0] rhs, lhs, odd;
        logic [63:0]  n, cn;
        vmag_result_t res;
        x = mag16(d[15:0]);  y = mag16(d[31:16]); z = mag16(d[47:32]);
        dx = mag16(d[63:48]); dy = mag16(d[79:64]); dz = mag16(d[95:80]);
        s = x*x + y*y + z*z;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c*c <= s) r = c;
        end
        n = 0;
        if (s != 0) begin
            rhs = 128'(x*x*dx*dx + y*y*dy*dy + z*z*dz*dz) * 128'd4
                  * 128'(SCALE) * 128'(SCALE);
            for (int b = 23; b >= 0; b--) begin
                cn = n | (64'd1 << b);
                odd = 128'(2*cn - 1);
                lhs = odd * odd * (128'(s) << 16);
                if (lhs <= rhs) n = cn;
            end
            if (n > 64'(ERR_MAX)) n = 64'(ERR_MAX);
        end
        res.magnitude = r[15:0];
        res.error_units = n[ERR_W-1:0];
        res.zero_vector = (s == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // sends one item; outside burst mode, sometimes after a random gap
    task automatic send_vector(input logic [95:0] d);
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        expected_results.push_back(predict_magnitude(d));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] rand_vector();
        logic [95:0] d;
        for (int i = 0; i < 6; i++) d[16*i +: 16] = rand_comp();
        return d;
    endfunction

    // receiver stall pattern and long hold-off
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (stall_mode) begin
            m_tready <= ($urandom_range(0, 2) != 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        vmag_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result item");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.magnitude)
                    report_mismatch("magnitude", m_tdata[15:0], want.magnitude);
                if (m_tdata[36:16] !== want.error_units)
                    report_mismatch("error_units", m_tdata[36:16], want.error_units);
                if (m_tuser[0] !== want.zero_vector)
                    report_mismatch("zero_vector", m_tuser[0], want.zero_vector);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        send_vector('0);
        send_vector({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
        send_vector({48'h0, 16'h8000, 16'h8000, 16'h8000});
        send_vector({{3{16'h8000}}, {3{16'h8000}}});
        send_vector({{3{16'h7FFF}}, {3{16'h7FFF}}});
        send_vector({{3{16'h8000}}, 16'h0000, 16'h0000, 16'h0001});
        send_vector({{3{16'h7FFF}}, 16'h0000, 16'h0000, 16'h0100});
        send_vector({16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100});
        send_vector({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_vector({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        for (int i = 0; i < 4; i++)
            send_vector({{3{ext[i]}}, ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4]});
        // zero vector with nonzero errors
        send_vector({{3{16'h7FFF}}, 48'h0});
        send_vector({{3{16'h8000}}, 48'h0});
    endtask

    task automatic test_random();
        burst_mode = 1'b0;
        for (int i = 0; i < 300; i++) begin
            send_vector(rand_vector());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 40; i++) send_vector(rand_vector());
        stall_mode = 1'b0;
        for (int i = 0; i < 60; i++) send_vector(rand_vector());
        stall_mode = 1'b1;
    endtask

    initial begin
        int wait_cycles;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        finish_sending();
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
